/* hw/rtl/generational_handle_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// generational_handle_allocator_core_macros.svh
// Assertion macros used by the handle allocator controller (gha_ctrl).
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define GHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must never be true outside reset
`define GHA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GHA_ASSERT(lbl, prop, msg)
`define GHA_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* hw/rtl/gha_pkg.sv */
// ----------------------------------------------------------------------------
// gha_pkg
// Types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gha_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int INDEX_BITS = 20;
    localparam int GEN_BITS   = 12;
    localparam int HANDLE_BITS = INDEX_BITS + GEN_BITS;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int COUNT_BITS = SLOT_BITS + 1;
    // free stack entry: generation of the freed slot above the slot index
    localparam int STK_BITS   = GEN_BITS + SLOT_BITS;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_QUERY   = 2'd2
    } gha_cmd_e;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_STALE = 2'd2
    } gha_status_e;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } gha_state_e;

    typedef struct packed {
        logic [1:0]             command;
        logic [HANDLE_BITS-1:0] handle;
    } gha_req_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] new_handle;
        logic                   alive;
        logic [1:0]             status;
    } gha_rsp_t;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        logic [GEN_BITS-1:0]  wdata;
        logic [SLOT_BITS-1:0] raddr;
    } gha_gen_port_t;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        logic [STK_BITS-1:0]  wdata;
        logic [SLOT_BITS-1:0] raddr;
    } gha_stk_port_t;

endpackage

/* hw/rtl/gha_ram.sv */
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/gha_ctrl.sv */
// ----------------------------------------------------------------------------
// gha_ctrl
// Command sequencer: issues table reads on accept, then does the
// read-modify-write of the generation table and free stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "generational_handle_allocator_core_macros.svh"

module gha_ctrl
    import gha_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gha_req_t            req,
    output logic                done,
    output gha_rsp_t            rsp,
    output gha_gen_port_t       gen_port,
    input  logic [GEN_BITS-1:0] gen_rdata,
    output gha_stk_port_t       stk_port,
    input  logic [STK_BITS-1:0] stk_rdata
);

    gha_state_e state_reg, state_next;
    gha_req_t   cmd_reg;
    logic [COUNT_BITS-1:0] free_count_reg, free_count_next;
    logic [SLOT_BITS-1:0]  highest_reg, highest_next;
    logic       done_reg, done_next;
    gha_rsp_t   rsp_reg, rsp_next;

    logic accept;
    logic [INDEX_BITS-1:0] h_slot;
    logic [GEN_BITS-1:0]   h_gen;
    logic [SLOT_BITS-1:0]  h_slot_low;
    logic                  in_range;
    logic                  alive_h;
    logic [GEN_BITS-1:0]   gen_inc;
    logic [SLOT_BITS-1:0]  pop_slot;
    logic [GEN_BITS-1:0]   pop_gen;
    logic [SLOT_BITS-1:0]  new_slot;
    logic                  can_grow;

    assign accept = start && (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy      = 1'b0;
        done_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // decode of the latched handle
    assign h_slot     = cmd_reg.handle[INDEX_BITS-1:0];
    assign h_gen      = cmd_reg.handle[HANDLE_BITS-1:INDEX_BITS];
    assign h_slot_low = h_slot[SLOT_BITS-1:0];
    assign in_range   = (h_slot != '0)
                     && (32'(h_slot) <= 32'(highest_reg))
                     && (32'(h_slot) < 32'(SLOT_COUNT));
    assign alive_h    = in_range && (gen_rdata == h_gen) && gen_rdata[0];
    assign gen_inc    = gen_rdata + GEN_BITS'(1);

    assign pop_slot   = stk_rdata[SLOT_BITS-1:0];
    assign pop_gen    = stk_rdata[STK_BITS-1:SLOT_BITS] + GEN_BITS'(1);
    assign new_slot   = highest_reg + SLOT_BITS'(1);
    assign can_grow   = (COUNT_BITS'(highest_reg) + COUNT_BITS'(1))
                      < COUNT_BITS'(SLOT_COUNT);

    // reads are issued at accept; freed slots never change generation while
    // on the stack, so a pop needs no table read
    always_comb
    begin
        gen_port.raddr  = req.handle[SLOT_BITS-1:0];
        stk_port.raddr  = SLOT_BITS'(free_count_reg - COUNT_BITS'(1));

        gen_port.we     = 1'b0;
        gen_port.waddr  = h_slot_low;
        gen_port.wdata  = gen_inc;
        stk_port.we     = 1'b0;
        stk_port.waddr  = free_count_reg[SLOT_BITS-1:0];
        stk_port.wdata  = {gen_inc, h_slot_low};

        free_count_next = free_count_reg;
        highest_next    = highest_reg;
        rsp_next        = '0;

        if (state_reg == ST_EXEC)
        begin
            case (cmd_reg.command)
                CMD_CREATE:
                begin
                    if (free_count_reg != '0)
                    begin
                        free_count_next     = free_count_reg - COUNT_BITS'(1);
                        gen_port.we         = 1'b1;
                        gen_port.waddr      = pop_slot;
                        gen_port.wdata      = pop_gen;
                        rsp_next.new_handle = {pop_gen, INDEX_BITS'(pop_slot)};
                    end
                    else if (can_grow)
                    begin
                        // fresh slot: generation is set to 1
                        highest_next        = new_slot;
                        gen_port.we         = 1'b1;
                        gen_port.waddr      = new_slot;
                        gen_port.wdata      = GEN_BITS'(1);
                        rsp_next.new_handle = {GEN_BITS'(1), INDEX_BITS'(new_slot)};
                    end
                    else
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                end
                CMD_DESTROY:
                begin
                    if (alive_h && (free_count_reg < COUNT_BITS'(SLOT_COUNT)))
                    begin
                        gen_port.we     = 1'b1;
                        stk_port.we     = 1'b1;
                        free_count_next = free_count_reg + COUNT_BITS'(1);
                    end
                    else
                    begin
                        rsp_next.status = STATUS_STALE;
                    end
                end
                CMD_QUERY:
                begin
                    if (!in_range)
                    begin
                        rsp_next.status = STATUS_STALE;
                    end
                    else
                    begin
                        rsp_next.alive = alive_h;
                    end
                end
                default:
                begin
                    rsp_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_count_reg <= '0;
            highest_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            highest_reg    <= highest_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `GHA_ASSERT(a_done_after_exec, (done_reg == $past(state_reg == ST_EXEC)), "result beat without a preceding execute cycle")
    `GHA_ASSERT_NEVER(a_free_le_used, (32'(free_count_reg) > 32'(highest_reg)), "more free slots than slots ever used")
    `GHA_ASSERT(a_full_only_when_full, ((done_reg && rsp_reg.status == STATUS_FULL) |-> (free_count_reg == '0 && 32'(highest_reg) == SLOT_COUNT - 1)), "full reported with slots available")
    `GHA_ASSERT(a_created_gen_odd, ((done_reg && rsp_reg.new_handle != '0) |-> rsp_reg.new_handle[INDEX_BITS]), "created handle has even generation")

endmodule

/* hw/rtl/generational_handle_allocator_core.sv */
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Result: done strobes a result beat, registered from the execute state after
// start is taken; busy is high in that state, the read-then-write pass through
// the generation table and free stack RAMs, and start is taken only when idle.
// Reset: slot counters clear at once, no clearing pass; the generation table
// is used only up to the highest slot ever used, so it needs no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_allocator_core
    import gha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  gha_req_t req,
    output logic     done,
    output gha_rsp_t rsp
);

    gha_gen_port_t       gen_port;
    gha_stk_port_t       stk_port;
    logic [GEN_BITS-1:0] gen_rdata;
    logic [STK_BITS-1:0] stk_rdata;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .gen_port  (gen_port),
        .gen_rdata (gen_rdata),
        .stk_port  (stk_port),
        .stk_rdata (stk_rdata)
    );

    gha_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_port.we),
        .waddr (gen_port.waddr),
        .wdata (gen_port.wdata),
        .raddr (gen_port.raddr),
        .rdata (gen_rdata)
    );

    gha_ram #(
        .WIDTH (STK_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_port.we),
        .waddr (stk_port.waddr),
        .wdata (stk_port.wdata),
        .raddr (stk_port.raddr),
        .rdata (stk_rdata)
    );

endmodule
